FILE: sv/tsg_pkg.sv
// Shared constants and types of the trapezoid step compare generator.
// No dependencies; used by tsg_div and trapezoid_step_compare_generator.
package tsg_pkg;

  localparam int unsigned FillDepth   = 32;
  localparam int unsigned CntW        = $clog2(FillDepth + 1);
  localparam int unsigned FreqW       = 18;
  localparam int unsigned FreqQ8W     = FreqW + 8;
  localparam int unsigned NumW        = 42;
  localparam int unsigned IterW       = 6;
  localparam int unsigned TickW       = 24;
  localparam int unsigned PerNumW     = TickW + 8 + 1;

  localparam logic [FreqW-1:0] FreqCapHz   = 18'd250000;
  localparam logic [15:0]      StartOffset = 16'd10;
  localparam logic [IterW-1:0] ItersRamp   = IterW'(NumW);
  localparam logic [IterW-1:0] ItersPeriod = IterW'(PerNumW);

  // Divider launch control
  typedef struct packed {
    logic             start;
    logic [IterW-1:0] iters;
  } div_req_t;

endpackage

FILE: sv/tsg_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on tsg_pkg for widths and the launch control struct.
module tsg_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tsg_pkg::div_req_t             req_i,
  input  logic [tsg_pkg::NumW-1:0]      numer_i,  // left aligned
  input  logic [tsg_pkg::FreqQ8W-1:0]   denom_i,
  output logic                          done_o,
  output logic [tsg_pkg::NumW-1:0]      quot_o
);

  logic [tsg_pkg::FreqQ8W-1:0] rem_q;
  logic [tsg_pkg::FreqQ8W-1:0] den_q;
  logic [tsg_pkg::NumW-1:0]    num_q;
  logic [tsg_pkg::NumW-1:0]    quo_q;
  logic [tsg_pkg::IterW-1:0]   cnt_q;
  logic                        busy_q;
  logic                        done_q;

  logic [tsg_pkg::FreqQ8W:0]   trial;
  logic [tsg_pkg::FreqQ8W:0]   diff;
  logic                        ge;

  always_comb begin
    trial = {rem_q, num_q[tsg_pkg::NumW-1]};
    ge    = (trial >= {1'b0, den_q});
    diff  = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // Pulse done with the last quotient bit
      done_q <= !req_i.start && busy_q && (cnt_q == tsg_pkg::IterW'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == tsg_pkg::IterW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      den_q <= denom_i;
      num_q <= numer_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[tsg_pkg::FreqQ8W-1:0] : trial[tsg_pkg::FreqQ8W-1:0];
      num_q <= {num_q[tsg_pkg::NumW-2:0], 1'b0};
      quo_q <= {quo_q[tsg_pkg::NumW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: sv/trapezoid_step_compare_generator.sv
// Top level of the trapezoid step compare generator: sequencer, profile
// registers and output stage. Depends on tsg_pkg and tsg_div.
//
// Usage:
//   Slave stream takes one command per transfer: tuser[0] is the opcode
//   (0 = start the move and fill, 1 = refill), tdata carries the timer
//   counter value and the buffer currently read by DMA. Each command yields
//   up to 32 master-stream transfers, one per pulse, with the absolute
//   16-bit compare time, the pulse index, the target buffer in tuser and
//   tlast on the final transfer of the fill. A fill with no pulses left
//   produces nothing.
//   Each pulse runs two passes through one shared bit-serial divider: the
//   ramp interpolation (skipped in cruise and past the end) and the period
//   conversion. A command is taken in StIdle and sized in StPrep before
//   its first pulse is computed.
//   s_axis_tready is high only while no fill is in progress.
//   A stalled master side holds the current transfer; the next pulse is
//   computed meanwhile and waits in the sequencer until the output register
//   frees up. The next command is taken once the last result is registered.
//   Reset clears the pulse counter and time accumulator and loads the
//   default profile. Write the profile registers only while idle.
module trapezoid_step_compare_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Profile register writes
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // Command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] counter_value, [16] read_buffer
  input  logic [0:0]  s_axis_tuser,   // [0] opcode
  // Compare value stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] compare_value, [47:16] pulse_number
  output logic [0:0]  m_axis_tuser,   // [0] buffer_select
  output logic        m_axis_tlast
);

  localparam logic [2:0] RegTotal = 3'd0;
  localparam logic [2:0] RegAccel = 3'd1;
  localparam logic [2:0] RegDecel = 3'd2;
  localparam logic [2:0] RegStart = 3'd3;
  localparam logic [2:0] RegMax   = 3'd4;
  localparam logic [2:0] RegEnd   = 3'd5;
  localparam logic [2:0] RegTick  = 3'd6;

  localparam logic OpStart = 1'b0;

  localparam int unsigned FW  = tsg_pkg::FreqW;
  localparam int unsigned QW  = tsg_pkg::FreqQ8W;
  localparam int unsigned CW  = tsg_pkg::CntW;

  typedef enum logic [2:0] {
    StIdle, StPrep, StPhase, StMul, StDivA, StFreq, StDivB, StEmit
  } state_e;

  typedef enum logic {
    RampUp, RampDown
  } ramp_e;

  // Profile registers
  logic [31:0]      total_q;
  logic [15:0]      accel_q;
  logic [15:0]      decel_q;
  logic [FW-1:0]    start_f_q;
  logic [FW-1:0]    max_f_q;
  logic [FW-1:0]    end_f_q;
  logic [23:0]      tick_q;

  // Move state
  logic [31:0]      pc_q;
  logic [15:0]      acc_q;

  // Sequencer
  state_e           state_q;
  ramp_e            ramp_q;
  logic [CW-1:0]    cnt_q;
  logic             sel_q;
  logic [FW-1:0]    mx_q;
  logic [FW-1:0]    st_q;
  logic [FW-1:0]    en_q;
  logic [31:0]      ds_q;
  logic [FW-1:0]    mul_a_q;
  logic [15:0]      mul_b_q;
  logic [QW-1:0]    f_q;

  // Output stage
  logic             out_valid_q;
  logic [15:0]      out_cmp_q;
  logic [31:0]      out_pulse_q;
  logic             out_sel_q;
  logic             out_last_q;

  // Combinational helpers
  logic                         in_xfer;
  logic                         emit_go;
  logic [FW-1:0]                mx_c;
  logic [31:0]                  rem_c;
  logic [CW-1:0]                n_c;
  logic [FW+15:0]               prod_c;
  logic [QW-1:0]                f_eff_c;
  logic [tsg_pkg::PerNumW-1:0]  per_num_c;
  logic [15:0]                  delta_c;
  logic [15:0]                  period_c;
  logic [QW-1:0]                ramp_q8_c;
  tsg_pkg::div_req_t            div_req;
  logic [tsg_pkg::NumW-1:0]     div_num;
  logic [QW-1:0]                div_den;
  logic                         div_done;
  logic [tsg_pkg::NumW-1:0]     div_quot;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign emit_go = !out_valid_q || m_axis_tready;

  always_comb begin
    mx_c      = (max_f_q > tsg_pkg::FreqCapHz) ? tsg_pkg::FreqCapHz : max_f_q;
    rem_c     = total_q - pc_q;
    n_c       = (rem_c < 32'(tsg_pkg::FillDepth)) ? rem_c[CW-1:0]
                                                  : CW'(tsg_pkg::FillDepth);
    prod_c    = mul_a_q * mul_b_q;
    f_eff_c   = (f_q == '0) ? QW'(256) : f_q;
    per_num_c = {1'b0, tick_q, 8'b0} + tsg_pkg::PerNumW'(f_eff_c >> 1);
    delta_c   = 16'(pc_q - ds_q);
    ramp_q8_c = div_quot[QW-1:0];
    // Period of zero is bumped to one tick
    period_c  = (div_quot[tsg_pkg::PerNumW-1:0] == '0) ? 16'd1 : div_quot[15:0];
  end

  // Launch the divider: ramp interpolation from the product of the registered
  // operands, period conversion from the tick rate and the pulse frequency
  always_comb begin
    div_req.start = 1'b0;
    div_req.iters = tsg_pkg::ItersRamp;
    div_num       = {prod_c, 8'b0};
    div_den       = (ramp_q == RampUp) ? QW'(accel_q) : QW'(decel_q);
    if (state_q == StMul) begin
      div_req.start = 1'b1;
    end else if (state_q == StFreq) begin
      div_req.start = 1'b1;
      div_req.iters = tsg_pkg::ItersPeriod;
      div_num       = {per_num_c, {(tsg_pkg::NumW - tsg_pkg::PerNumW){1'b0}}};
      div_den       = f_eff_c;
    end
  end

  tsg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (div_req),
    .numer_i (div_num),
    .denom_i (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Profile register writes; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= 32'd0;
      accel_q   <= 16'd15000;
      decel_q   <= 16'd15000;
      start_f_q <= 18'd1000;
      max_f_q   <= 18'd250000;
      end_f_q   <= 18'd1000;
      tick_q    <= 24'd1000000;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegTotal: total_q   <= cfg_data_i;
        RegAccel: accel_q   <= cfg_data_i[15:0];
        RegDecel: decel_q   <= cfg_data_i[15:0];
        RegStart: start_f_q <= cfg_data_i[FW-1:0];
        RegMax:   max_f_q   <= cfg_data_i[FW-1:0];
        RegEnd:   end_f_q   <= cfg_data_i[FW-1:0];
        RegTick:  tick_q    <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // Sequencer with move state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pc_q        <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      ramp_q      <= RampUp;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_cmp_q   <= '0;
      out_pulse_q <= '0;
      out_sel_q   <= 1'b0;
      out_last_q  <= 1'b0;
      mx_q        <= '0;
      st_q        <= '0;
      en_q        <= '0;
      ds_q        <= '0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
      f_q         <= '0;
    end else begin
      // Drop a taken transfer; in StEmit the emit below sets the valid
      if (out_valid_q && m_axis_tready && (state_q != StEmit)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_xfer) begin
            sel_q <= ~s_axis_tdata[16];
            if (s_axis_tuser[0] == OpStart) begin
              acc_q <= s_axis_tdata[15:0] + tsg_pkg::StartOffset;
              pc_q  <= '0;
            end
            state_q <= StPrep;
          end
        end
        StPrep: begin
          // Clamp the profile and size the fill
          mx_q <= mx_c;
          st_q <= (start_f_q > mx_c) ? mx_c : start_f_q;
          en_q <= (end_f_q > mx_c) ? mx_c : end_f_q;
          ds_q <= total_q - 32'(decel_q);
          if (pc_q < total_q) begin
            cnt_q   <= n_c;
            state_q <= StPhase;
          end else begin
            state_q <= StIdle;
          end
        end
        StPhase: begin
          // Pick the profile segment of the current pulse
          if (pc_q < 32'(accel_q)) begin
            ramp_q  <= RampUp;
            mul_a_q <= mx_q - st_q;
            mul_b_q <= pc_q[15:0];
            state_q <= StMul;
          end else if (pc_q < ds_q) begin
            f_q     <= {mx_q, 8'b0};
            state_q <= StFreq;
          end else if (pc_q < total_q) begin
            if (decel_q == '0) begin
              f_q     <= {mx_q, 8'b0};
              state_q <= StFreq;
            end else begin
              ramp_q  <= RampDown;
              mul_a_q <= mx_q - en_q;
              mul_b_q <= delta_c;
              state_q <= StMul;
            end
          end else begin
            f_q     <= {en_q, 8'b0};
            state_q <= StFreq;
          end
        end
        StMul: begin
          state_q <= StDivA;
        end
        StDivA: begin
          if (div_done) begin
            f_q <= (ramp_q == RampUp) ? {st_q, 8'b0} + ramp_q8_c
                                      : {mx_q, 8'b0} - ramp_q8_c;
            state_q <= StFreq;
          end
        end
        StFreq: begin
          state_q <= StDivB;
        end
        StDivB: begin
          if (div_done) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          // Hold here while the previous transfer is still pending
          if (emit_go) begin
            out_valid_q <= 1'b1;
            out_cmp_q   <= acc_q + period_c;
            out_pulse_q <= pc_q;
            out_sel_q   <= sel_q;
            out_last_q  <= (cnt_q == CW'(1));
            acc_q       <= acc_q + period_c;
            pc_q        <= pc_q + 32'd1;
            cnt_q       <= cnt_q - 1'b1;
            state_q     <= (cnt_q == CW'(1)) ? StIdle : StPhase;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_pulse_q, out_cmp_q};
  assign m_axis_tuser  = out_sel_q;
  assign m_axis_tlast  = out_last_q;

endmodule
